// ===== rtl/core/psan_pkg.sv =====
package psan_pkg;

  typedef enum logic [2:0] {
    RSN_NONE     = 3'd0,
    RSN_EMPTY    = 3'd1,
    RSN_LEAD     = 3'd2,
    RSN_CHAR     = 3'd3,
    RSN_LONG     = 3'd4,
    RSN_COMP     = 3'd5,
    RSN_RESERVED = 3'd6,
    RSN_EXT      = 3'd7
  } reason_e;

  typedef struct packed {
    logic [7:0] ch;
    logic       is_slash;
    logic       is_dot;
    logic       is_bad;
  } norm_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       end_of_path;
    logic       accepted;
    reason_e    reason;
  } result_t;

  localparam logic [7:0] CH_SLASH     = 8'h2f;
  localparam logic [7:0] CH_BACKSLASH = 8'h5c;
  localparam logic [7:0] CH_DOT       = 8'h2e;
  localparam logic [7:0] CH_COLON     = 8'h3a;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_UPPER_A   = 8'h41;
  localparam logic [7:0] CH_UPPER_Z   = 8'h5a;
  localparam logic [7:0] CASE_OFFSET  = 8'h20;

  localparam int unsigned RESERVED_LEN = 14;
  localparam logic [8*RESERVED_LEN-1:0] RESERVED_STR = "fs-aliases.lua";

  localparam int unsigned EXT_MAX = 5;
  localparam int unsigned NUM_EXT = 10;
  localparam int unsigned ExtLenW = $clog2(EXT_MAX + 1);

  // byte k of each extension sits at bits 8k
  localparam logic [8*EXT_MAX-1:0] EXT_CHARS [NUM_EXT] = '{
    {16'h0, "gfc"},
    {16'h0, "mvq"},
    {8'h0,  "msaw"},
    {16'h0, "lld"},
    {24'h0, "os"},
    "bilyd",
    {16'h0, "exe"},
    {16'h0, "moc"},
    {16'h0, "tab"},
    {16'h0, "dmc"}
  };

  localparam logic [ExtLenW-1:0] EXT_LEN [NUM_EXT] = '{
    3'd3, 3'd3, 3'd4, 3'd3, 3'd2, 3'd5, 3'd3, 3'd3, 3'd3, 3'd3
  };

  function automatic logic [7:0] reserved_char(input logic [3:0] idx);
    reserved_char = RESERVED_STR[8*(RESERVED_LEN-1-int'(idx)) +: 8];
  endfunction

endpackage

// ===== rtl/core/psan_norm.sv =====
module psan_norm (
  input  logic [7:0]     char_code_i,
  output psan_pkg::norm_t norm_o
);
  import psan_pkg::*;

  logic [7:0] slash_fixed;
  logic [7:0] lowered;

  always_comb begin
    slash_fixed = (char_code_i == CH_BACKSLASH) ? CH_SLASH : char_code_i;
    if (slash_fixed >= CH_UPPER_A && slash_fixed <= CH_UPPER_Z) begin
      lowered = slash_fixed + CASE_OFFSET;
    end else begin
      lowered = slash_fixed;
    end
    norm_o.ch       = lowered;
    norm_o.is_slash = (lowered == CH_SLASH);
    norm_o.is_dot   = (lowered == CH_DOT);
    norm_o.is_bad   = (lowered < CH_SPACE) || (lowered == CH_COLON);
  end

endmodule

// ===== rtl/core/psan_state.sv =====
module psan_state #(
  parameter int unsigned PATH_LIMIT = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic              is_end_i,
  input  logic              full_mode_i,
  input  psan_pkg::norm_t   norm_i,
  output psan_pkg::result_t result_o
);
  import psan_pkg::*;

  localparam int unsigned PosW = $clog2(PATH_LIMIT) + 1;
  localparam logic [PosW-1:0] PosMax = PosW'(PATH_LIMIT);
  localparam logic [PosW-1:0] LongAt = PosW'(PATH_LIMIT - 1);

  logic [PosW-1:0]      pos_q, pos_d;
  logic [1:0]           comp_len_q, comp_len_d;
  logic                 all_dots_q, all_dots_d;
  reason_e              err_q, err_d;
  logic                 dot_seen_q, dot_seen_d;
  logic [8*EXT_MAX-1:0] ext_q, ext_d;
  logic [ExtLenW-1:0]   ext_len_q, ext_len_d;
  logic                 ext_long_q, ext_long_d;
  logic                 rmatch_q, rmatch_d;

  logic    comp_bad;
  logic    ext_forbidden;
  reason_e end_err;

  assign comp_bad = (comp_len_q == 2'd0) || ((comp_len_q <= 2'd2) && all_dots_q);

  always_comb begin
    ext_forbidden = 1'b0;
    for (int e = 0; e < NUM_EXT; e++) begin
      if (ext_len_q == EXT_LEN[e] && ext_q == EXT_CHARS[e]) begin
        ext_forbidden = 1'b1;
      end
    end
    ext_forbidden = ext_forbidden && dot_seen_q && !ext_long_q;
  end

  always_comb begin
    end_err = err_q;
    if (end_err == RSN_NONE) begin
      if (pos_q == '0) begin
        end_err = RSN_EMPTY;
      end else if (comp_bad) begin
        end_err = RSN_COMP;
      end
    end
    if (end_err == RSN_NONE && full_mode_i) begin
      if (rmatch_q && int'(pos_q) == RESERVED_LEN) begin
        end_err = RSN_RESERVED;
      end else if (ext_forbidden) begin
        end_err = RSN_EXT;
      end
    end
  end

  always_comb begin
    pos_d      = pos_q;
    comp_len_d = comp_len_q;
    all_dots_d = all_dots_q;
    err_d      = err_q;
    dot_seen_d = dot_seen_q;
    ext_d      = ext_q;
    ext_len_d  = ext_len_q;
    ext_long_d = ext_long_q;
    rmatch_d   = rmatch_q;

    if (is_end_i) begin
      result_o.out_char    = '0;
      result_o.end_of_path = 1'b1;
      result_o.accepted    = (end_err == RSN_NONE);
      result_o.reason      = end_err;
      pos_d      = '0;
      comp_len_d = '0;
      all_dots_d = 1'b1;
      err_d      = RSN_NONE;
      dot_seen_d = 1'b0;
      ext_d      = '0;
      ext_len_d  = '0;
      ext_long_d = 1'b0;
      rmatch_d   = 1'b1;
    end else begin
      result_o.out_char    = norm_i.ch;
      result_o.end_of_path = 1'b0;
      result_o.accepted    = 1'b0;
      result_o.reason      = RSN_NONE;

      if (err_q == RSN_NONE) begin
        if (pos_q == '0 && norm_i.is_slash) begin
          err_d = RSN_LEAD;
        end else if (pos_q >= LongAt) begin
          err_d = RSN_LONG;
        end else if (norm_i.is_bad) begin
          err_d = RSN_CHAR;
        end else if (norm_i.is_slash && comp_bad) begin
          err_d = RSN_COMP;
        end
      end

      if (norm_i.is_slash) begin
        comp_len_d = '0;
        all_dots_d = 1'b1;
      end else begin
        if (comp_len_q != 2'd3) begin
          comp_len_d = comp_len_q + 2'd1;
        end
        if (!norm_i.is_dot) begin
          all_dots_d = 1'b0;
        end
      end

      if (int'(pos_q) >= RESERVED_LEN || reserved_char(pos_q[3:0]) != norm_i.ch) begin
        rmatch_d = 1'b0;
      end

      if (norm_i.is_dot) begin
        dot_seen_d = 1'b1;
        ext_d      = '0;
        ext_len_d  = '0;
        ext_long_d = 1'b0;
      end else if (dot_seen_q) begin
        if (int'(ext_len_q) < EXT_MAX) begin
          ext_d[8*ext_len_q +: 8] = norm_i.ch;
          ext_len_d = ext_len_q + 1'b1;
        end else begin
          ext_long_d = 1'b1;
        end
      end

      if (pos_q < PosMax) begin
        pos_d = pos_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      comp_len_q <= '0;
      all_dots_q <= 1'b1;
      err_q      <= RSN_NONE;
      dot_seen_q <= 1'b0;
      ext_q      <= '0;
      ext_len_q  <= '0;
      ext_long_q <= 1'b0;
      rmatch_q   <= 1'b1;
    end else if (step_i) begin
      pos_q      <= pos_d;
      comp_len_q <= comp_len_d;
      all_dots_q <= all_dots_d;
      err_q      <= err_d;
      dot_seen_q <= dot_seen_d;
      ext_q      <= ext_d;
      ext_len_q  <= ext_len_d;
      ext_long_q <= ext_long_d;
      rmatch_q   <= rmatch_d;
    end
  end

`ifndef SYNTHESIS
  // path state returns to its clean value after an end item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && is_end_i |=> pos_q == '0 && err_q == RSN_NONE && rmatch_q && !dot_seen_q)
    else $error("path state not cleared after end item");

  // a held reason never changes until the path ends
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && !is_end_i && err_q != RSN_NONE |=> err_q == $past(err_q))
    else $error("first error overwritten");

  // the end result carries the error already held
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    is_end_i && err_q != RSN_NONE |-> result_o.reason == err_q && !result_o.accepted)
    else $error("held error lost at end of path");

  // byte count never runs past the limit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= PosMax)
    else $error("byte position beyond limit");
`endif

endmodule

// ===== rtl/core/path_sanitizer_stream.sv =====
// path sanitizer, one path byte per item
// input channel: in_valid_i / in_ready_o carry char_code_i and is_end_i;
//   an item with is_end_i set closes the path and its byte is ignored
// output channel: out_valid_o / out_ready_i carry one result per item:
//   the normalized byte, or on the end item end_of_path_o with
//   accepted_o and reject_reason_o
// cfg_we_i / cfg_wdata_i write full_check_mode, reset value 1; write
//   only while no path is in flight
// latency: result valid one cycle after the input accept edge (input
//   register, then result register); throughput one item per cycle, set by
//   the single-cycle update of the per-path state between the two registers
// reset: both registers empty, path state clean, full check mode on
// a stalled receiver holds the result register; one more item waits in
//   the input register, then in_ready_o drops until the result is taken
// after each end item the path state clears for the next path
module path_sanitizer_stream #(
  parameter int unsigned PATH_LIMIT = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] char_code_i,
  input  logic       is_end_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_char_o,
  output logic       end_of_path_o,
  output logic       accepted_o,
  output logic [2:0] reject_reason_o,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i
);
  import psan_pkg::*;

  logic       s1_valid_q;
  logic [7:0] s1_char_q;
  logic       s1_end_q;
  logic       out_valid_q;
  result_t    out_q;
  logic       mode_q;

  logic    out_free;
  logic    s1_adv;
  norm_t   norm;
  result_t result;

  assign out_free   = !out_valid_q || out_ready_i;
  assign s1_adv     = s1_valid_q && out_free;
  assign in_ready_o = !s1_valid_q || out_free;

  psan_norm u_norm (
    .char_code_i(s1_char_q),
    .norm_o     (norm)
  );

  psan_state #(
    .PATH_LIMIT(PATH_LIMIT)
  ) u_state (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (s1_adv),
    .is_end_i   (s1_end_q),
    .full_mode_i(mode_q),
    .norm_i     (norm),
    .result_o   (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      mode_q      <= 1'b1;
    end else begin
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (out_free) begin
        out_valid_q <= s1_valid_q;
      end
      if (cfg_we_i) begin
        mode_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_char_q <= char_code_i;
      s1_end_q  <= is_end_i;
    end
    if (s1_adv) begin
      out_q <= result;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_char_o      = out_q.out_char;
  assign end_of_path_o   = out_q.end_of_path;
  assign accepted_o      = out_q.accepted;
  assign reject_reason_o = out_q.reason;

endmodule
